FILE: rtl/lat_pkg.sv
// ---------------------------------------------------------------------------
// lat_pkg: shared types and constants of the toroidal life grid
// Grid geometry, request codes, request word layout and rule thresholds.
// ---------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int unsigned GRID_WIDTH  = 64;
  localparam int unsigned GRID_HEIGHT = 64;
  localparam int unsigned ROW_W       = $clog2(GRID_HEIGHT);
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned GEN_W       = 32;

  typedef logic [GRID_WIDTH-1:0] row_t;
  typedef logic [ROW_W-1:0]      row_idx_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [GEN_W-1:0]      gen_t;
  typedef logic [1:0]            req_code_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_type_e;

  typedef struct packed {
    req_code_t req_type;
    coord_t    col;
    coord_t    row;
    logic      write_value;
  } req_t;

  // neighbor count thresholds of the birth-3 / survive-2-3 rule
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

endpackage

`default_nettype wire

FILE: rtl/lat_req_if.sv
// ---------------------------------------------------------------------------
// lat_req_if: request channel of the life grid
// Valid/ready channel carrying one request word.
// ---------------------------------------------------------------------------
`default_nettype none

interface lat_req_if;
  logic               valid;
  logic               ready;
  lat_pkg::req_code_t req_type;
  lat_pkg::coord_t    col;
  lat_pkg::coord_t    row;
  logic               write_value;

  modport source (output valid, req_type, col, row, write_value, input ready);
  modport sink   (input valid, req_type, col, row, write_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lat_rsp_if.sv
// ---------------------------------------------------------------------------
// lat_rsp_if: response channel of the life grid
// Valid/ready channel carrying the cell value and generation count.
// ---------------------------------------------------------------------------
`default_nettype none

interface lat_rsp_if;
  logic          valid;
  logic          ready;
  logic          cell_out;
  lat_pkg::gen_t generation;

  modport source (output valid, cell_out, generation, input ready);
  modport sink   (input valid, cell_out, generation, output ready);
endinterface

`default_nettype wire

FILE: rtl/lat_row_cell.sv
// ---------------------------------------------------------------------------
// lat_row_cell: one row of the grid ring
// Holds one grid row and takes its neighbor's row whenever the ring moves.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_row_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  lat_pkg::row_t row_i,
  output lat_pkg::row_t row_o
);
  import lat_pkg::*;

  row_t row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (shift_i) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

FILE: rtl/lat_row_update.sv
// ---------------------------------------------------------------------------
// lat_row_update: next-generation row
// Applies the birth-3 / survive-2-3 rule to every cell of one row, with
// columns wrapping around.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_row_update (
  input  lat_pkg::row_t above_i,
  input  lat_pkg::row_t mid_i,
  input  lat_pkg::row_t below_i,
  output lat_pkg::row_t next_o
);
  import lat_pkg::*;

  // left and right neighbor of every column, wrapping at the edges
  row_t above_l, above_r;
  row_t mid_l,   mid_r;
  row_t below_l, below_r;

  assign above_l = {above_i[GRID_WIDTH-2:0], above_i[GRID_WIDTH-1]};
  assign above_r = {above_i[0], above_i[GRID_WIDTH-1:1]};
  assign mid_l   = {mid_i[GRID_WIDTH-2:0], mid_i[GRID_WIDTH-1]};
  assign mid_r   = {mid_i[0], mid_i[GRID_WIDTH-1:1]};
  assign below_l = {below_i[GRID_WIDTH-2:0], below_i[GRID_WIDTH-1]};
  assign below_r = {below_i[0], below_i[GRID_WIDTH-1:1]};

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    logic [3:0] live;
    assign live = {3'b0, above_l[c]} + {3'b0, above_i[c]} + {3'b0, above_r[c]}
                + {3'b0, mid_l[c]}                         + {3'b0, mid_r[c]}
                + {3'b0, below_l[c]} + {3'b0, below_i[c]} + {3'b0, below_r[c]};
    assign next_o[c] = mid_i[c] ? ((live == SURVIVE_LOW) || (live == SURVIVE_HIGH))
                                : (live == BIRTH_COUNT);
  end

endmodule

`default_nettype wire

FILE: rtl/life_automaton_torus_grid_top.sv
// ---------------------------------------------------------------------------
// life_automaton_torus_grid_top: toroidal life grid with generation counter
// Write, read or advance a 64x64 wrapping grid of one-bit cells.
// ---------------------------------------------------------------------------
// The grid lives in a ring of 64 row registers that rotates by one row per
// cycle while a request runs, except that the ring is held on its last position
// while the previous response word is not taken. Every request (write, read,
// step or the unused code) takes one full turn of the ring, through the one
// row-update unit at the head of the ring; a step computes one new row per
// turn position from the head row and its two neighbors. The next request is
// accepted in the cycle after the response is produced, while that response
// still waits in the output register. Reset clears all cells and the generation count at once.
`default_nettype none

module life_automaton_torus_grid_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  lat_req_if.sink   req_i,
  lat_rsp_if.source rsp_o
);
  import lat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e   state_q, state_d;
  req_t     req_q;
  row_idx_t pos_q;
  row_t     prev_old_q;
  row_t     first_old_q;
  logic     rd_bit_q;
  gen_t     gen_q;
  logic     out_valid_q;
  logic     out_cell_q;
  gen_t     out_gen_q;

  row_t ring[GRID_HEIGHT];
  row_t head_row;
  row_t above_row;
  row_t below_row;
  row_t new_row;
  row_t wb_row;
  logic last_pos;
  logic advance;
  logic finish;
  logic in_grid;
  logic hit;
  logic accept;
  logic is_step;

  assign accept   = req_i.valid && req_i.ready;
  assign head_row = ring[0];
  assign last_pos = (pos_q == row_idx_t'(GRID_HEIGHT - 1));
  // hold the ring on its last position while the previous word is not taken
  assign advance  = (state_q == ST_RUN) && !(last_pos && out_valid_q && !rsp_o.ready);
  assign finish   = advance && last_pos;
  assign in_grid  = (32'(req_q.col) < GRID_WIDTH) && (32'(req_q.row) < GRID_HEIGHT);
  assign hit      = in_grid && (pos_q == req_q.row);
  assign is_step  = (req_q.req_type == REQ_STEP);

  // old neighbors: the tail still holds old row H-1 at the first position,
  // and old row 0 has been replaced by the time the last row is computed
  assign above_row = (pos_q == '0) ? ring[GRID_HEIGHT-1] : prev_old_q;
  assign below_row = last_pos ? first_old_q : ring[1];

  lat_row_update u_update (
    .above_i (above_row),
    .mid_i   (head_row),
    .below_i (below_row),
    .next_o  (new_row)
  );

  always_comb begin
    wb_row = head_row;
    priority if (is_step) begin
      wb_row = new_row;
    end else if ((req_q.req_type == REQ_WRITE) && hit) begin
      wb_row[req_q.col] = req_q.write_value;
    end
  end

  for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_ring
    if (k == GRID_HEIGHT - 1) begin : g_tail
      lat_row_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (advance),
        .row_i   (wb_row),
        .row_o   (ring[k])
      );
    end else begin : g_body
      lat_row_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (advance),
        .row_i   (ring[k+1]),
        .row_o   (ring[k])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q <= '0;
      end else if (advance) begin
        pos_q <= pos_q + row_idx_t'(1);
      end
      if (finish && is_step) begin
        gen_q <= gen_q + gen_t'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type    <= req_i.req_type;
      req_q.col         <= req_i.col;
      req_q.row         <= req_i.row;
      req_q.write_value <= req_i.write_value;
      rd_bit_q          <= 1'b0;
    end else if (advance) begin
      prev_old_q <= head_row;
      if (pos_q == '0) begin
        first_old_q <= head_row;
      end
      if ((req_q.req_type == REQ_READ) && hit) begin
        rd_bit_q <= head_row[req_q.col];
      end
    end
    if (finish) begin
      // the last row is read on the finishing cycle itself
      out_cell_q <= ((req_q.req_type == REQ_READ) && hit) ? head_row[req_q.col] : rd_bit_q;
      out_gen_q  <= is_step ? gen_q + gen_t'(1) : gen_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_out   = out_cell_q;
  assign rsp_o.generation = out_gen_q;

endmodule

`default_nettype wire

FILE: rtl/lat_checker.sv
// ---------------------------------------------------------------------------
// lat_checker: port-level checks of the life grid
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input logic          rsp_cell_i,
  input lat_pkg::gen_t rsp_gen_i
);

  // block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while previous one still running");

  // a response never appears the cycle after a request is taken
  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i))
    else $error("response appeared too early");

  // a new response only comes out of a running request
  a_rsp_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response without a running request");

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_cell_i) && $stable(rsp_gen_i)))
    else $error("stalled response changed");

endmodule

bind life_automaton_torus_grid_top lat_checker u_lat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_cell_i  (rsp_o.cell_out),
  .rsp_gen_i   (rsp_o.generation)
);

`default_nettype wire
